[hw/rtl/gps_pkg.sv]
package gps_pkg;

  localparam int GRID_W     = 64;
  localparam int GRID_H     = 64;
  localparam int OPEN_DEPTH = 8192;
  localparam int NCELLS     = GRID_W * GRID_H;

  localparam int COL_W   = $clog2(GRID_W);
  localparam int ROW_W   = $clog2(GRID_H);
  localparam int CELL_W  = $clog2(NCELLS);
  localparam int OPEN_AW = $clog2(OPEN_DEPTH);
  localparam int CNT_W   = OPEN_AW + 1;
  localparam int COST_W  = 12;
  localparam int KEY_W   = COST_W + 1;
  localparam int MAN_W   = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;

  localparam int CMD_W      = 2;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  // direction codes of the move from parent into a cell
  localparam logic [1:0] DIR_PX = 2'd0;
  localparam logic [1:0] DIR_MX = 2'd1;
  localparam logic [1:0] DIR_PZ = 2'd2;
  localparam logic [1:0] DIR_MZ = 2'd3;

  localparam logic [1:0] MODE_BFS      = 2'd0;
  localparam logic [1:0] MODE_DFS      = 2'd1;
  localparam logic [1:0] MODE_DIJKSTRA = 2'd2;
  localparam logic [1:0] MODE_ASTAR    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_COL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_ROW  = 3'd4;

  localparam logic [STAT_W-1:0] ST_EXPANDED = 3'd0;
  localparam logic [STAT_W-1:0] ST_GOAL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_PATH  = 3'd2;
  localparam logic [STAT_W-1:0] ST_IDLE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_PATH     = 3'd4;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd5;
  localparam logic [STAT_W-1:0] ST_LOAD_ACK = 3'd6;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_PATH  = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_CLR_ALL, OP_CLR_SEEN, OP_LOAD, OP_SEED, OP_IDLE_RES,
    OP_NOPATH, OP_SEL_INIT, OP_SCAN_RD, OP_SCAN_CMP, OP_ENT_RD, OP_ENT_GET,
    OP_SH_RD, OP_SH_WR, OP_REM_END, OP_CEL_RD, OP_GOAL, OP_EXP_INIT, OP_NB_SKIP,
    OP_NB_RD, OP_NB_EVAL, OP_OVERFLOW, OP_EXPANDED, OP_PT_RD, OP_PT_GO
  } op_t;

  typedef struct packed {
    cmd_t cmd;
    logic clr_last;
    logic searching;
    logic found;
    logic cnt_zero;
    logic cost_mode;
    logic scan_last;
    logic sh_more;
    logic stale;
    logic is_goal;
    logic k_last;
    logic nb_in;
    logic nb_over;
  } sts_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [COST_W-1:0] cost;
    logic [KEY_W-1:0]  key;
  } entry_t;

  typedef struct packed {
    logic              seen;
    logic [COST_W-1:0] best;
    logic [1:0]        par;
  } cellw_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [COST_W-1:0] cost;
    logic              last;
  } res_t;

  function automatic logic [CELL_W-1:0] gps_cell(input logic [COL_W-1:0] c,
                                                 input logic [ROW_W-1:0] r);
    return CELL_W'(CELL_W'(r) * CELL_W'(GRID_W)) + CELL_W'(c);
  endfunction

  function automatic logic [MAN_W-1:0] gps_manhattan(input logic [COL_W-1:0] c,
                                                     input logic [ROW_W-1:0] r,
                                                     input logic [COL_W-1:0] gc,
                                                     input logic [ROW_W-1:0] gr);
    logic [COL_W-1:0] dc;
    logic [ROW_W-1:0] dr;
    dc = (c >= gc) ? c - gc : gc - c;
    dr = (r >= gr) ? r - gr : gr - r;
    return MAN_W'(dc) + MAN_W'(dr);
  endfunction

  // depth-first visits +z,-z,+x,-x
  function automatic logic [1:0] gps_dir(input logic [1:0] mode, input logic [1:0] k);
    return (mode == MODE_DFS) ? (k ^ 2'd2) : k;
  endfunction

endpackage

[hw/rtl/gps_ifs.sv]
interface gps_in_if;
  logic                         valid;
  logic                         ready;
  logic [gps_pkg::CMD_W-1:0]    command;
  logic [gps_pkg::COL_W-1:0]    load_col;
  logic [gps_pkg::ROW_W-1:0]    load_row;
  logic                         is_wall;
  modport source(output valid, command, load_col, load_row, is_wall, input ready);
  modport sink(input valid, command, load_col, load_row, is_wall, output ready);
endinterface

interface gps_out_if;
  logic                         valid;
  logic                         ready;
  logic [gps_pkg::STAT_W-1:0]   status;
  logic [gps_pkg::COL_W-1:0]    cell_col;
  logic [gps_pkg::ROW_W-1:0]    cell_row;
  logic [gps_pkg::COST_W-1:0]   path_cost;
  logic                         last;
  modport source(output valid, status, cell_col, cell_row, path_cost, last, input ready);
  modport sink(input valid, status, cell_col, cell_row, path_cost, last, output ready);
endinterface

interface gps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gps_pkg::CFG_IDX_W-1:0]   index;
  logic [gps_pkg::CFG_DATA_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/gps_dp.sv]
module gps_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gps_pkg::op_t                  op,
  output gps_pkg::sts_t                 sts,
  input  logic                          cfg_we,
  input  logic [gps_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [gps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [gps_pkg::CMD_W-1:0]     in_command,
  input  logic [gps_pkg::COL_W-1:0]     in_load_col,
  input  logic [gps_pkg::ROW_W-1:0]     in_load_row,
  input  logic                          in_is_wall,
  output gps_pkg::res_t                 res
);

  // configuration registers
  logic [1:0]                  mode_cfg_r;
  logic [gps_pkg::COL_W-1:0]   scol_r, gcol_r;
  logic [gps_pkg::ROW_W-1:0]   srow_r, grow_r;

  // latched per-search values
  logic [1:0]                  run_mode_r;
  logic [gps_pkg::COL_W-1:0]   run_gc_r, run_sc_r;
  logic [gps_pkg::ROW_W-1:0]   run_gr_r, run_sr_r;

  gps_pkg::cmd_t               cmd_r;
  logic [gps_pkg::COL_W-1:0]   lcol_r;
  logic [gps_pkg::ROW_W-1:0]   lrow_r;
  logic                        lwall_r;

  logic                        searching_r, found_r;
  logic [gps_pkg::COL_W-1:0]   cur_col_r;
  logic [gps_pkg::ROW_W-1:0]   cur_row_r;
  logic [gps_pkg::OPEN_AW-1:0] head_r;
  logic [gps_pkg::CNT_W-1:0]   count_r;
  logic [gps_pkg::CELL_W-1:0]  clr_r;
  logic [gps_pkg::CNT_W-1:0]   i_r, j_r;
  logic [gps_pkg::OPEN_AW-1:0] idx_r;
  logic [gps_pkg::KEY_W-1:0]   bkey_r;
  logic [gps_pkg::COL_W-1:0]   e_col_r;
  logic [gps_pkg::ROW_W-1:0]   e_row_r;
  logic [gps_pkg::COST_W-1:0]  e_cost_r, newc_r;
  logic [1:0]                  k_r;
  gps_pkg::res_t               res_r;

  // memories
  logic                        wall_mem [gps_pkg::NCELLS];
  gps_pkg::cellw_t             cell_mem [gps_pkg::NCELLS];
  gps_pkg::entry_t             open_mem [gps_pkg::OPEN_DEPTH];
  logic                        wall_rd_r;
  gps_pkg::cellw_t             cell_rd_r;
  gps_pkg::entry_t             open_rd_r;

  logic                        wall_we, wall_wd, mem_re;
  logic [gps_pkg::CELL_W-1:0]  wall_wa, cell_wa, mem_ra;
  logic                        cell_we;
  gps_pkg::cellw_t             cell_wd;
  logic                        open_we, open_re;
  logic [gps_pkg::OPEN_AW-1:0] open_wa, open_ra;
  gps_pkg::entry_t             open_wd;

  logic [1:0]                  dir;
  logic                        nb_in, take, full, cost_mode, s_in, ld_in, at_start;
  logic [gps_pkg::COL_W-1:0]   n_col, p_col;
  logic [gps_pkg::ROW_W-1:0]   n_row, p_row;
  logic                        p_in;
  logic [gps_pkg::CELL_W-1:0]  n_cell, e_cell;
  logic [gps_pkg::KEY_W-1:0]   nb_key, seed_key;
  logic [gps_pkg::OPEN_AW-1:0] push_slot;

  assign cost_mode = (run_mode_r == gps_pkg::MODE_DIJKSTRA) ||
                     (run_mode_r == gps_pkg::MODE_ASTAR);
  assign dir       = gps_pkg::gps_dir(run_mode_r, k_r);
  assign s_in      = (int'(scol_r) < gps_pkg::GRID_W) && (int'(srow_r) < gps_pkg::GRID_H);
  assign ld_in     = (int'(lcol_r) < gps_pkg::GRID_W) && (int'(lrow_r) < gps_pkg::GRID_H);
  assign e_cell    = gps_pkg::gps_cell(e_col_r, e_row_r);
  assign n_cell    = gps_pkg::gps_cell(n_col, n_row);
  assign full      = count_r == gps_pkg::CNT_W'(gps_pkg::OPEN_DEPTH);
  assign push_slot = head_r + count_r[gps_pkg::OPEN_AW-1:0];
  assign take      = !wall_rd_r && (!cell_rd_r.seen || (cost_mode && newc_r < cell_rd_r.best));
  assign nb_key    = (run_mode_r == gps_pkg::MODE_ASTAR) ?
                     gps_pkg::KEY_W'(newc_r) +
                     gps_pkg::KEY_W'(gps_pkg::gps_manhattan(n_col, n_row, run_gc_r, run_gr_r)) :
                     gps_pkg::KEY_W'(newc_r);
  assign seed_key  = (mode_cfg_r == gps_pkg::MODE_ASTAR) ?
                     gps_pkg::KEY_W'(gps_pkg::gps_manhattan(scol_r, srow_r, gcol_r, grow_r)) :
                     '0;
  assign at_start  = (cur_col_r == run_sc_r) && (cur_row_r == run_sr_r);

  // neighbor of the expanded cell in the current direction
  always_comb begin
    n_col = e_col_r;
    n_row = e_row_r;
    nb_in = 1'b0;
    case (dir)
      gps_pkg::DIR_PX: begin
        n_col = e_col_r + 1'b1;
        nb_in = int'(e_col_r) < gps_pkg::GRID_W - 1;
      end
      gps_pkg::DIR_MX: begin
        n_col = e_col_r - 1'b1;
        nb_in = e_col_r != '0;
      end
      gps_pkg::DIR_PZ: begin
        n_row = e_row_r + 1'b1;
        nb_in = int'(e_row_r) < gps_pkg::GRID_H - 1;
      end
      default: begin
        n_row = e_row_r - 1'b1;
        nb_in = e_row_r != '0;
      end
    endcase
  end

  // parent of the path cursor: step back against the stored move
  always_comb begin
    p_col = cur_col_r;
    p_row = cur_row_r;
    p_in  = 1'b0;
    case (cell_rd_r.par)
      gps_pkg::DIR_PX: begin
        p_col = cur_col_r - 1'b1;
        p_in  = cur_col_r != '0;
      end
      gps_pkg::DIR_MX: begin
        p_col = cur_col_r + 1'b1;
        p_in  = int'(cur_col_r) < gps_pkg::GRID_W - 1;
      end
      gps_pkg::DIR_PZ: begin
        p_row = cur_row_r - 1'b1;
        p_in  = cur_row_r != '0;
      end
      default: begin
        p_row = cur_row_r + 1'b1;
        p_in  = int'(cur_row_r) < gps_pkg::GRID_H - 1;
      end
    endcase
  end

  // memory port control
  always_comb begin
    wall_we = 1'b0;
    wall_wa = clr_r;
    wall_wd = 1'b0;
    cell_we = 1'b0;
    cell_wa = clr_r;
    cell_wd = '0;
    mem_re  = 1'b0;
    mem_ra  = e_cell;
    open_we = 1'b0;
    open_wa = push_slot;
    open_wd = open_rd_r;
    open_re = 1'b0;
    open_ra = head_r + i_r[gps_pkg::OPEN_AW-1:0];
    case (op)
      gps_pkg::OP_CLR_ALL: begin
        wall_we = 1'b1;
        cell_we = 1'b1;
      end
      gps_pkg::OP_CLR_SEEN: cell_we = 1'b1;
      gps_pkg::OP_LOAD: begin
        wall_we = ld_in;
        wall_wa = gps_pkg::gps_cell(lcol_r, lrow_r);
        wall_wd = lwall_r;
      end
      gps_pkg::OP_SEED: begin
        cell_we = s_in;
        cell_wa = gps_pkg::gps_cell(scol_r, srow_r);
        cell_wd = '{seen: 1'b1, best: '0, par: gps_pkg::DIR_PX};
        open_we = s_in;
        open_wa = '0;
        open_wd = '{col: scol_r, row: srow_r, cost: '0, key: seed_key};
      end
      gps_pkg::OP_SCAN_RD: open_re = 1'b1;
      gps_pkg::OP_ENT_RD: begin
        open_re = 1'b1;
        open_ra = head_r + idx_r;
      end
      gps_pkg::OP_SH_RD: begin
        open_re = 1'b1;
        open_ra = head_r + gps_pkg::OPEN_AW'(j_r + 1'b1);
      end
      gps_pkg::OP_SH_WR: begin
        open_we = 1'b1;
        open_wa = head_r + j_r[gps_pkg::OPEN_AW-1:0];
      end
      gps_pkg::OP_CEL_RD: mem_re = 1'b1;
      gps_pkg::OP_NB_RD: begin
        mem_re = 1'b1;
        mem_ra = n_cell;
      end
      gps_pkg::OP_NB_EVAL: begin
        cell_we = take;
        cell_wa = n_cell;
        cell_wd = '{seen: 1'b1, best: newc_r, par: dir};
        open_we = take;
        open_wd = '{col: n_col, row: n_row, cost: newc_r, key: nb_key};
      end
      gps_pkg::OP_PT_RD: begin
        mem_re = 1'b1;
        mem_ra = gps_pkg::gps_cell(cur_col_r, cur_row_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wall_we) wall_mem[wall_wa] <= wall_wd;
    if (mem_re)  wall_rd_r <= wall_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    if (mem_re)  cell_rd_r <= cell_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (open_we) open_mem[open_wa] <= open_wd;
    if (open_re) open_rd_r <= open_mem[open_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_cfg_r  <= '0;
      scol_r      <= '0;
      srow_r      <= '0;
      gcol_r      <= '0;
      grow_r      <= '0;
      searching_r <= 1'b0;
      found_r     <= 1'b0;
      count_r     <= '0;
      head_r      <= '0;
      clr_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          gps_pkg::REG_MODE:      mode_cfg_r <= cfg_data[1:0];
          gps_pkg::REG_START_COL: scol_r     <= gps_pkg::COL_W'(cfg_data);
          gps_pkg::REG_START_ROW: srow_r     <= gps_pkg::ROW_W'(cfg_data);
          gps_pkg::REG_GOAL_COL:  gcol_r     <= gps_pkg::COL_W'(cfg_data);
          gps_pkg::REG_GOAL_ROW:  grow_r     <= gps_pkg::ROW_W'(cfg_data);
          default: ;
        endcase
      end
      case (op)
        gps_pkg::OP_LATCH: begin
          cmd_r   <= gps_pkg::cmd_t'(in_command);
          lcol_r  <= in_load_col;
          lrow_r  <= in_load_row;
          lwall_r <= in_is_wall;
        end
        gps_pkg::OP_CLR_ALL, gps_pkg::OP_CLR_SEEN: clr_r <= clr_r + 1'b1;
        gps_pkg::OP_LOAD: res_r <= '{status: gps_pkg::ST_LOAD_ACK, col: lcol_r,
                                     row: lrow_r, cost: '0, last: 1'b0};
        gps_pkg::OP_SEED: begin
          run_mode_r  <= mode_cfg_r;
          run_gc_r    <= gcol_r;
          run_gr_r    <= grow_r;
          run_sc_r    <= s_in ? scol_r : '0;
          run_sr_r    <= s_in ? srow_r : '0;
          head_r      <= '0;
          count_r     <= s_in ? gps_pkg::CNT_W'(1) : '0;
          found_r     <= 1'b0;
          cur_col_r   <= '0;
          cur_row_r   <= '0;
          searching_r <= 1'b1;
          res_r <= '{status: gps_pkg::ST_IDLE, col: scol_r, row: srow_r,
                     cost: '0, last: 1'b0};
        end
        gps_pkg::OP_IDLE_RES: res_r <= '{status: gps_pkg::ST_IDLE, default: '0};
        gps_pkg::OP_NOPATH: begin
          searching_r <= 1'b0;
          res_r <= '{status: gps_pkg::ST_NO_PATH, default: '0};
        end
        gps_pkg::OP_SEL_INIT: begin
          i_r   <= '0;
          idx_r <= (run_mode_r == gps_pkg::MODE_DFS) ?
                   gps_pkg::OPEN_AW'(count_r - 1'b1) : '0;
        end
        gps_pkg::OP_SCAN_CMP: begin
          // strict compare keeps the earliest of equal keys
          if (i_r == '0 || open_rd_r.key < bkey_r) begin
            bkey_r <= open_rd_r.key;
            idx_r  <= i_r[gps_pkg::OPEN_AW-1:0];
          end
          i_r <= i_r + 1'b1;
        end
        gps_pkg::OP_ENT_GET: begin
          e_col_r  <= open_rd_r.col;
          e_row_r  <= open_rd_r.row;
          e_cost_r <= open_rd_r.cost;
          j_r      <= gps_pkg::CNT_W'(idx_r);
        end
        gps_pkg::OP_SH_WR: j_r <= j_r + 1'b1;
        gps_pkg::OP_REM_END: begin
          if (idx_r == '0) head_r <= head_r + 1'b1;
          count_r <= count_r - 1'b1;
        end
        gps_pkg::OP_GOAL: begin
          searching_r <= 1'b0;
          found_r     <= 1'b1;
          cur_col_r   <= e_col_r;
          cur_row_r   <= e_row_r;
          res_r <= '{status: gps_pkg::ST_GOAL, col: e_col_r, row: e_row_r,
                     cost: e_cost_r, last: 1'b0};
        end
        gps_pkg::OP_EXP_INIT: begin
          newc_r <= (e_cost_r < gps_pkg::COST_MAX) ? e_cost_r + 1'b1 : gps_pkg::COST_MAX;
          k_r    <= '0;
        end
        gps_pkg::OP_NB_SKIP: k_r <= k_r + 1'b1;
        gps_pkg::OP_NB_EVAL: begin
          if (take) count_r <= count_r + 1'b1;
          k_r <= k_r + 1'b1;
        end
        gps_pkg::OP_OVERFLOW: begin
          searching_r <= 1'b0;
          res_r <= '{status: gps_pkg::ST_OVERFLOW, col: e_col_r, row: e_row_r,
                     cost: e_cost_r, last: 1'b0};
        end
        gps_pkg::OP_EXPANDED: res_r <= '{status: gps_pkg::ST_EXPANDED, col: e_col_r,
                                         row: e_row_r, cost: e_cost_r, last: 1'b0};
        gps_pkg::OP_PT_GO: begin
          if (at_start || !p_in) found_r <= 1'b0;
          if (!at_start && p_in) begin
            cur_col_r <= p_col;
            cur_row_r <= p_row;
          end
          res_r <= '{status: gps_pkg::ST_PATH, col: cur_col_r, row: cur_row_r,
                     cost: cell_rd_r.best, last: at_start};
        end
        default: ;
      endcase
    end
  end

  assign res = res_r;

  always_comb begin
    sts.cmd       = cmd_r;
    sts.clr_last  = clr_r == gps_pkg::CELL_W'(gps_pkg::NCELLS - 1);
    sts.searching = searching_r;
    sts.found     = found_r;
    sts.cnt_zero  = count_r == '0;
    sts.cost_mode = cost_mode;
    sts.scan_last = gps_pkg::CNT_W'(i_r + 1'b1) == count_r;
    sts.sh_more   = (idx_r != '0) && (gps_pkg::CNT_W'(j_r + 1'b1) < count_r);
    sts.stale     = cost_mode && (e_cost_r > cell_rd_r.best);
    sts.is_goal   = (e_col_r == run_gc_r) && (e_row_r == run_gr_r);
    sts.k_last    = k_r == 2'd3;
    sts.nb_in     = nb_in;
    sts.nb_over   = take && full;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= gps_pkg::CNT_W'(gps_pkg::OPEN_DEPTH))
    else $error("open count beyond store depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (op == gps_pkg::OP_NB_EVAL && take) |-> !full)
    else $error("push into a full open store");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    op == gps_pkg::OP_SCAN_CMP |-> i_r < count_r)
    else $error("scan past the held entries");

  a_goal_stops: assert property (@(posedge clk) disable iff (!rst_n)
    op == gps_pkg::OP_GOAL |=> (found_r && !searching_r))
    else $error("goal did not stop the search");

endmodule

[hw/rtl/gps_ctrl.sv]
module gps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  gps_pkg::sts_t sts,
  output gps_pkg::op_t  op
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISP, S_SWEEP, S_SEED, S_POP, S_SCAN_RD, S_SCAN_CMP,
    S_ENT_RD, S_ENT_GET, S_SHIFT, S_SH_WR, S_CEL_RD, S_CHK, S_NB, S_NB_EVAL,
    S_EXP, S_PT_GO, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    op        = gps_pkg::OP_NONE;
    case (state_r)
      S_CLR: begin
        op = gps_pkg::OP_CLR_ALL;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op        = gps_pkg::OP_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.cmd)
          gps_pkg::CMD_LOAD: begin
            op        = gps_pkg::OP_LOAD;
            state_nxt = S_OUT;
          end
          gps_pkg::CMD_START: state_nxt = S_SWEEP;
          gps_pkg::CMD_STEP: begin
            if (sts.searching) begin
              state_nxt = S_POP;
            end else begin
              op        = gps_pkg::OP_IDLE_RES;
              state_nxt = S_OUT;
            end
          end
          default: begin
            if (sts.found) begin
              op        = gps_pkg::OP_PT_RD;
              state_nxt = S_PT_GO;
            end else begin
              op        = gps_pkg::OP_IDLE_RES;
              state_nxt = S_OUT;
            end
          end
        endcase
      end
      S_SWEEP: begin
        op = gps_pkg::OP_CLR_SEEN;
        if (sts.clr_last) state_nxt = S_SEED;
      end
      S_SEED: begin
        op        = gps_pkg::OP_SEED;
        state_nxt = S_OUT;
      end
      S_POP: begin
        if (sts.cnt_zero) begin
          op        = gps_pkg::OP_NOPATH;
          state_nxt = S_OUT;
        end else begin
          op        = gps_pkg::OP_SEL_INIT;
          state_nxt = sts.cost_mode ? S_SCAN_RD : S_ENT_RD;
        end
      end
      S_SCAN_RD: begin
        op        = gps_pkg::OP_SCAN_RD;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        op        = gps_pkg::OP_SCAN_CMP;
        state_nxt = sts.scan_last ? S_ENT_RD : S_SCAN_RD;
      end
      S_ENT_RD: begin
        op        = gps_pkg::OP_ENT_RD;
        state_nxt = S_ENT_GET;
      end
      S_ENT_GET: begin
        op        = gps_pkg::OP_ENT_GET;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.sh_more) begin
          op        = gps_pkg::OP_SH_RD;
          state_nxt = S_SH_WR;
        end else begin
          op        = gps_pkg::OP_REM_END;
          state_nxt = sts.cost_mode ? S_CEL_RD : S_CHK;
        end
      end
      S_SH_WR: begin
        op        = gps_pkg::OP_SH_WR;
        state_nxt = S_SHIFT;
      end
      S_CEL_RD: begin
        op        = gps_pkg::OP_CEL_RD;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.stale) begin
          state_nxt = S_POP;
        end else if (sts.is_goal) begin
          op        = gps_pkg::OP_GOAL;
          state_nxt = S_OUT;
        end else begin
          op        = gps_pkg::OP_EXP_INIT;
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        if (sts.nb_in) begin
          op        = gps_pkg::OP_NB_RD;
          state_nxt = S_NB_EVAL;
        end else if (sts.k_last) begin
          op        = gps_pkg::OP_EXPANDED;
          state_nxt = S_OUT;
        end else begin
          op = gps_pkg::OP_NB_SKIP;
        end
      end
      S_NB_EVAL: begin
        if (sts.nb_over) begin
          op        = gps_pkg::OP_OVERFLOW;
          state_nxt = S_OUT;
        end else begin
          op        = gps_pkg::OP_NB_EVAL;
          state_nxt = sts.k_last ? S_EXP : S_NB;
        end
      end
      S_EXP: begin
        op        = gps_pkg::OP_EXPANDED;
        state_nxt = S_OUT;
      end
      S_PT_GO: begin
        op        = gps_pkg::OP_PT_GO;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_nxt == S_OUT);
    end
  end

endmodule

[hw/rtl/grid_path_search_stepper_unit.sv]
// Grid path search stepper. Holds a 64x64 maze of 4-connected cells and runs
// breadth-first, depth-first, Dijkstra or A-star searches one pop per step
// word, with further pops where a stale entry is popped, then walks the
// parent marks from goal back to start one cell per path word. Every input
// word returns exactly one result word; the block works one word at a time
// and takes the next input once the result has been taken. After reset a
// clearing pass over the 4096 cells runs before the first input word is
// taken; configuration writes are taken at any time. A start command runs
// the sweep that clears the seen marks, one cell per cycle. A step reads
// and evaluates each neighbor inside the grid and skips each neighbor
// outside it. In Dijkstra and A-star mode a step also reads the popped
// cell's record, and each pop scans every held open entry to find the least
// key, then closes the gap left by the popped entry by moving the entries
// behind it; a stale pop repeats that work within the same step. The open
// store is a single-port read/single-port write memory, and these sweeps
// over it set the rate.
module grid_path_search_stepper_unit (
  input logic         clk,
  input logic         rst_n,
  gps_in_if.sink      in_ch,
  gps_out_if.source   out_ch,
  gps_cfg_if.sink     cfg_ch
);

  gps_pkg::op_t  op;
  gps_pkg::sts_t sts;
  gps_pkg::res_t res;

  // always take register writes
  assign cfg_ch.ready = 1'b1;

  gps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .op        (op)
  );

  gps_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (op),
    .sts         (sts),
    .cfg_we      (cfg_ch.valid),
    .cfg_idx     (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .in_command  (in_ch.command),
    .in_load_col (in_ch.load_col),
    .in_load_row (in_ch.load_row),
    .in_is_wall  (in_ch.is_wall),
    .res         (res)
  );

  // hold the result word until taken
  assign out_ch.status    = res.status;
  assign out_ch.cell_col  = res.col;
  assign out_ch.cell_row  = res.row;
  assign out_ch.path_cost = res.cost;
  assign out_ch.last      = res.last;

endmodule
